// ===== hdl/hsf_pkg.sv =====
`timescale 1ns / 1ps

package hsf_pkg;

  localparam int MAX_OBJECTS = 16;
  localparam int CNT_W       = 6;
  localparam int ID_W        = 16;
  localparam int DIST_W      = 32;
  localparam int TYPE_W      = 2;
  localparam int OCNT_W      = 5;
  localparam int TDATA_W     = 72;

  localparam logic [TYPE_W-1:0] TYPE_ENTER  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_EXIT   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_HOLLOW = 2'd2;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 6'sd31;
  localparam logic signed [CNT_W-1:0] CNT_MIN = -6'sd32;

  typedef enum logic [1:0] {
    OP_MERGE,
    OP_UNION,
    OP_INTERSECT,
    OP_DIFFERENCE
  } op_t;

  typedef enum logic [1:0] {
    REG_OPERATION,
    REG_OBJECT_COUNT,
    REG_PRIMARY_ID,
    REG_GROUP_ID
  } reg_idx_t;

  typedef struct packed {
    op_t               operation;
    logic [OCNT_W-1:0] object_count;
    logic [ID_W-1:0]   primary_id;
    logic [ID_W-1:0]   group_id;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   object_id;
    logic [ID_W-1:0]   child_id;
    logic [TYPE_W-1:0] hit_type;
    logic [DIST_W-1:0] distance;
    logic              first;
    logic              last;
  } hit_t;

  typedef struct packed {
    logic              keep;
    logic [ID_W-1:0]   owner_id;
    logic [ID_W-1:0]   primitive_id;
    logic [TYPE_W-1:0] out_type;
  } hit_res_t;

endpackage

// ===== hdl/hsf_classify.sv =====
`timescale 1ns / 1ps

module hsf_classify
  import hsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  cfg_t     cfg,
  input  hit_t     hit,
  output hit_res_t res
);

  logic signed [CNT_W-1:0] inside_count;
  logic                    inside_primary;
  logic signed [CNT_W-1:0] inside_count_next;
  logic                    inside_primary_next;

  logic signed [CNT_W-1:0] cnt;
  logic                    prim;
  logic signed [CNT_W-1:0] cnt_up;
  logic signed [CNT_W-1:0] cnt_dn;
  logic                    is_enter;
  logic                    is_exit;
  logic [OCNT_W-1:0]       n_eff;
  logic signed [CNT_W:0]   cnt_x;
  logic signed [CNT_W:0]   up_x;
  logic signed [CNT_W:0]   n_x;
  logic signed [CNT_W:0]   n_m1_x;
  logic                    keep;
  logic [TYPE_W-1:0]       otype;

  // first hit of a list starts from a clean state
  assign cnt      = hit.first ? '0 : inside_count;
  assign prim     = hit.first ? 1'b0 : inside_primary;
  assign cnt_up   = (cnt == CNT_MAX) ? cnt : cnt + 6'sd1;
  assign cnt_dn   = (cnt == CNT_MIN) ? cnt : cnt - 6'sd1;
  assign is_enter = (hit.hit_type == TYPE_ENTER);
  assign is_exit  = (hit.hit_type == TYPE_EXIT);

  always_comb begin
    if (cfg.object_count == '0) begin
      n_eff = OCNT_W'(1);
    end else if (cfg.object_count > OCNT_W'(MAX_OBJECTS)) begin
      n_eff = OCNT_W'(MAX_OBJECTS);
    end else begin
      n_eff = cfg.object_count;
    end
  end

  assign cnt_x  = {cnt[CNT_W-1], cnt};
  assign up_x   = {cnt_up[CNT_W-1], cnt_up};
  assign n_x    = $signed({{(CNT_W+1-OCNT_W){1'b0}}, n_eff});
  assign n_m1_x = n_x - 7'sd1;

  always_comb begin
    inside_count_next   = cnt;
    inside_primary_next = prim;
    keep                = 1'b0;
    otype               = hit.hit_type;
    case (cfg.operation)
      OP_MERGE: begin
        keep = 1'b1;
      end
      OP_UNION: begin
        if (is_enter) begin
          inside_count_next = cnt_up;
        end else if (is_exit) begin
          inside_count_next = cnt_dn;
        end
        keep = (inside_count_next <= 6'sd0) || (is_enter && cnt == 6'sd0);
      end
      OP_INTERSECT: begin
        if (is_enter) begin
          inside_count_next = cnt_up;
          keep              = up_x >= n_x;
        end else if (is_exit) begin
          inside_count_next = cnt_dn;
          keep              = cnt_x >= n_x;
        end else begin
          keep = cnt_x >= n_m1_x;
        end
      end
      OP_DIFFERENCE: begin
        if (hit.object_id == cfg.primary_id) begin
          inside_primary_next = is_enter;
          keep                = cnt <= 6'sd0;
        end else if (is_enter) begin
          inside_count_next = cnt_up;
          otype             = TYPE_EXIT;
          keep              = prim && (cnt_up == 6'sd1);
        end else if (is_exit) begin
          inside_count_next = cnt_dn;
          otype             = TYPE_ENTER;
          keep              = prim && (cnt_dn == 6'sd0);
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_count   <= '0;
      inside_primary <= 1'b0;
    end else if (en) begin
      inside_count   <= inside_count_next;
      inside_primary <= inside_primary_next;
    end
  end

  assign res.keep         = keep;
  assign res.owner_id     = keep ? cfg.group_id : hit.object_id;
  assign res.primitive_id = (hit.child_id == '0) ? hit.object_id : hit.child_id;
  assign res.out_type     = otype;

endmodule

// ===== hdl/hsf_cfg_regs.sv =====
`timescale 1ns / 1ps

module hsf_cfg_regs
  import hsf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [1:0]      index,
  input  logic [ID_W-1:0] data,
  output cfg_t            cfg
);

  reg_idx_t idx;

  assign idx = reg_idx_t'(index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operation    <= OP_MERGE;
      cfg.object_count <= OCNT_W'(2);
      cfg.primary_id   <= ID_W'(1);
      cfg.group_id     <= ID_W'(1);
    end else if (we) begin
      unique case (idx)
        REG_OPERATION:    cfg.operation    <= op_t'(data[1:0]);
        REG_OBJECT_COUNT: cfg.object_count <= data[OCNT_W-1:0];
        REG_PRIMARY_ID:   cfg.primary_id   <= data;
        REG_GROUP_ID:     cfg.group_id     <= data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/csg_hit_span_filter_top.sv =====
`timescale 1ns / 1ps

// CSG hit span filter: classifies the distance-sorted hits of one CSG node.
// Input stream (s_*): one hit per transfer; s_tuser carries the first-of-list
// flag, s_tlast the last-of-list flag. Output stream (m_*): one result per
// hit, in order; m_tuser carries the keep flag, m_tlast copies the input last.
// Config port: cfg_we writes cfg_data into register cfg_index (0 operation,
// 1 object_count, 2 primary_id, 3 group_id); write only while the block is
// idle.
// Path: an accepted hit enters the input register, then passes the classify
// logic into the output register, where it shows on m_tvalid.
// Throughput: one hit per cycle when not stalled; the inside count and
// primary flag update in the same cycle the hit moves to the output register.
// Reset (rst, synchronous): registers return to merge / 2 / 1 / 1, the inside
// state clears, both pipeline stages empty.
// Stall: when m_tready is low the output register holds; the input register
// still takes one more hit, then s_tready drops until the output moves.

module csg_hit_span_filter_top
  import hsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // object_id[15:0], child_id[31:16], hit_type[33:32], distance[65:34]
  input  logic [TDATA_W-1:0] s_tdata,
  // first
  input  logic               s_tuser,
  input  logic               s_tlast,
  input  logic               s_tvalid,
  output logic               s_tready,
  // owner_id[15:0], primitive_id[31:16], out_type[33:32], out_distance[65:34]
  output logic [TDATA_W-1:0] m_tdata,
  // keep
  output logic               m_tuser,
  output logic               m_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ID_W-1:0]    cfg_data
);

  cfg_t     cfg;
  hit_t     hit;
  logic     hit_valid;
  hit_res_t res;
  logic     advance;

  logic [DIST_W-1:0] out_distance;
  hit_res_t          out_res;

  hsf_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  assign advance  = hit_valid && (!m_tvalid || m_tready);
  assign s_tready = !hit_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (s_tready) begin
      hit_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hit.object_id <= s_tdata[15:0];
      hit.child_id  <= s_tdata[31:16];
      hit.hit_type  <= s_tdata[33:32];
      hit.distance  <= s_tdata[65:34];
      hit.first     <= s_tuser;
      hit.last      <= s_tlast;
    end
  end

  hsf_classify u_classify (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cfg (cfg),
    .hit (hit),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res      <= res;
      out_distance <= hit.distance;
      m_tlast      <= hit.last;
    end
  end

  assign m_tuser = out_res.keep;
  assign m_tdata = {6'd0, out_distance, out_res.out_type, out_res.primitive_id,
                    out_res.owner_id};

endmodule

// ===== hdl/hsf_checker.sv =====
`timescale 1ns / 1ps

module hsf_checker
  import hsf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast,
  input logic               m_tvalid,
  input logic               m_tready
);

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // input only stalls behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // a held hit facing an empty output side shows in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 !m_tvalid |=> m_tvalid)
    else $error("result missing after accepted transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output changed while stalled");

endmodule

bind csg_hit_span_filter_top hsf_checker u_hsf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
